@@ sv/arp_reply_binding_checker_assert.svh @@
// assertion macros for the binding checker
`ifndef ARP_REPLY_BINDING_CHECKER_ASSERT_SVH
`define ARP_REPLY_BINDING_CHECKER_ASSERT_SVH

// same-cycle implication, masked during reset
`define ARBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arbc assertion failed");

// next-cycle implication, masked during reset
`define ARBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arbc assertion failed");

// next-cycle implication, also checked while reset is held
`define ARBC_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("arbc assertion failed");

`endif

@@ sv/arbc_pkg.sv @@
package arbc_pkg;

  localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
  localparam logic [15:0] OPCODE_REPLY = 16'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_IGNORED = 2'd0,
    VERDICT_UNKNOWN = 2'd1,
    VERDICT_CORRECT = 2'd2,
    VERDICT_POISON  = 2'd3
  } verdict_t;

  // one word travelling down the cell row
  typedef struct packed {
    logic        vld;
    logic        load;
    logic        arp;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic [47:0] hit_mac;
    logic [7:0]  hit_idx;
  } slot_t;

endpackage

@@ sv/arbc_if.sv @@
interface arbc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] eth_type;
  logic [15:0] arp_opcode;
  logic [31:0] sender_ip;
  logic [47:0] sender_mac;

  modport source (
    output valid, operation, eth_type, arp_opcode, sender_ip, sender_mac,
    input  ready
  );
  modport sink (
    input  valid, operation, eth_type, arp_opcode, sender_ip, sender_mac,
    output ready
  );
endinterface

interface arbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [47:0] trusted_mac;
  logic [7:0]  match_index;

  modport source (
    output valid, verdict, trusted_mac, match_index,
    input  ready
  );
  modport sink (
    input  valid, verdict, trusted_mac, match_index,
    output ready
  );
endinterface

@@ sv/arbc_cell.sv @@
module arbc_cell
  import arbc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  slot_t         slot_i,
  input  logic [CW-1:0] cnt_i,
  output slot_t         slot_o,
  output logic [CW-1:0] cnt_o
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [7:0]    IDX_LO = 8'(IDX);

  logic [31:0]   ent_ip_r;
  logic [47:0]   ent_mac_r;
  slot_t         slot_r;
  slot_t         slot_nxt;
  logic [CW-1:0] cnt_r;
  logic          wr;

  assign wr = adv && slot_i.vld && slot_i.load && (cnt_i == IDX_C);

  always_comb begin
    slot_nxt = slot_i;
    if (slot_i.vld && !slot_i.load && slot_i.arp && !slot_i.hit &&
        (IDX_C < cnt_i) && (ent_ip_r == slot_i.ip)) begin
      slot_nxt.hit     = 1'b1;
      slot_nxt.hit_mac = ent_mac_r;
      slot_nxt.hit_idx = IDX_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_ip_r  <= slot_i.ip;
      ent_mac_r <= slot_i.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (adv) begin
      slot_r <= slot_nxt;
      cnt_r  <= cnt_i;
    end
  end

  assign slot_o = slot_r;
  assign cnt_o  = cnt_r;

endmodule

@@ sv/arp_reply_binding_checker.sv @@
// ARP reply binding checker
// in_ch carries one word per item: operation 0 loads a trusted IP/MAC pair,
// operation 1 checks a received frame. out_ch carries one verdict word per
// check and nothing for a load.
// The table lives in a row of TABLE_DEPTH cells, one binding per cell. Every
// accepted word enters the first cell and moves one cell per cycle while the
// row advances; a load is written by the cell at the current fill count, a
// check is compared in each cell it passes and keeps the first hit.
// A word passes the TABLE_DEPTH cells and then the output register.
// Throughput: one item per cycle unless out_ch stalls, set by the cell row.
// Loads past TABLE_DEPTH are accepted and dropped.
// Reset empties the table and the row; no clearing pass is needed.
// When out_ch.ready is low with a word waiting, the whole row holds and
// in_ch.ready drops until the output word is taken.
module arp_reply_binding_checker
  import arbc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  arbc_in_if.sink      in_ch,
  arbc_out_if.source   out_ch
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  slot_t         chain [TABLE_DEPTH+1];
  logic [CW-1:0] cnt_chain [TABLE_DEPTH+1];

  logic          adv;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          full;
  logic          out_valid_r;
  logic [1:0]    verdict_r;
  logic [47:0]   trusted_mac_r;
  logic [7:0]    match_index_r;
  verdict_t      verdict_nxt;
  slot_t         head;
  slot_t         tail;

  assign adv  = !out_valid_r || out_ch.ready;
  assign full = (count_r == DEPTH_C);
  assign in_ch.ready = adv;

  always_comb begin
    head.vld     = in_ch.valid && ((in_ch.operation == OP_CHECK) || !full);
    head.load    = (in_ch.operation == OP_LOAD);
    head.arp     = (in_ch.eth_type == ETH_TYPE_ARP) &&
                   (in_ch.arp_opcode == OPCODE_REPLY);
    head.ip      = in_ch.sender_ip;
    head.mac     = in_ch.sender_mac;
    head.hit     = 1'b0;
    head.hit_mac = '0;
    head.hit_idx = '0;
  end
  assign chain[0]     = head;
  assign cnt_chain[0] = count_r;

  always_comb begin
    count_nxt = count_r;
    if (in_ch.valid && adv && (in_ch.operation == OP_LOAD) && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    arbc_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .slot_i (chain[k]),
      .cnt_i  (cnt_chain[k]),
      .slot_o (chain[k+1]),
      .cnt_o  (cnt_chain[k+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    if (!tail.arp) begin
      verdict_nxt = VERDICT_IGNORED;
    end else if (!tail.hit) begin
      verdict_nxt = VERDICT_UNKNOWN;
    end else if (tail.hit_mac == tail.mac) begin
      verdict_nxt = VERDICT_CORRECT;
    end else begin
      verdict_nxt = VERDICT_POISON;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.vld && !tail.load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r     <= verdict_nxt;
      trusted_mac_r <= tail.hit_mac;
      match_index_r <= tail.hit_idx;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.trusted_mac = trusted_mac_r;
  assign out_ch.match_index = match_index_r;

endmodule

@@ sv/arbc_chk.sv @@
`include "arp_reply_binding_checker_assert.svh"

module arbc_chk
  import arbc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [47:0] trusted_mac,
  input logic [7:0]  match_index
);

  logic        no_hit;
  logic        zero_fields;
  logic [57:0] out_word;

  assign no_hit      = (verdict == VERDICT_IGNORED) || (verdict == VERDICT_UNKNOWN);
  assign zero_fields = (trusted_mac == 48'd0) && (match_index == 8'd0);
  assign out_word    = {verdict, trusted_mac, match_index};

  `ARBC_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid)
  `ARBC_ASSERT_NOW(a_nomatch_zero, out_valid && no_hit, zero_fields)
  `ARBC_ASSERT_NEXT(a_stall_valid, out_valid && !out_ready, out_valid)
  `ARBC_ASSERT_NEXT(a_stall_word, out_valid && !out_ready, $stable(out_word))

endmodule

bind arp_reply_binding_checker arbc_chk u_arbc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .verdict     (out_ch.verdict),
  .trusted_mac (out_ch.trusted_mac),
  .match_index (out_ch.match_index)
);

@@ verif/arp_reply_binding_checker_tb.sv @@
`timescale 1ns / 100ps

module arp_reply_binding_checker_tb;
  import arbc_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int RANDOM_WORDS = 1780;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic        operation;
    logic [15:0] eth_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } frame_word_t;

  typedef struct {
    verdict_t    verdict;
    logic [47:0] mac;
    logic [7:0]  idx;
  } verdict_word_t;

  logic clk = 1'b0;
  logic rst_n;

  arbc_in_if  in_ch ();
  arbc_out_if out_ch ();

  arp_reply_binding_checker #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stimulus side
  frame_word_t   frame_queue [$];
  frame_word_t   cur_word;
  int            total_words = 0;
  int            words_sent = 0;

  // generator view of stored bindings
  logic [31:0]   stored_ips [$];
  logic [47:0]   first_mac_of [logic [31:0]];

  // binding table predictor
  logic [31:0]   bound_ip [TABLE_DEPTH];
  logic [47:0]   bound_mac [TABLE_DEPTH];
  int            bound_count = 0;
  verdict_word_t pending_verdicts [$];

  int            mismatch_count = 0;
  int            stall_cycles = 0;
  int            cycle_count = 0;
  logic          calm;

  assign calm = (cycle_count >= 1000) && (cycle_count < 1600);

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  task automatic add_word(input logic op, input logic [15:0] et, input logic [15:0] opc,
                          input logic [31:0] ip, input logic [47:0] mac);
    frame_queue.push_back('{op, et, opc, ip, mac});
    total_words++;
    if (op == OP_LOAD && stored_ips.size() < TABLE_DEPTH) begin
      stored_ips.push_back(ip);
      if (!first_mac_of.exists(ip)) first_mac_of[ip] = mac;
    end
  endtask

  task automatic judge_word(input frame_word_t w);
    verdict_word_t v;
    v.verdict = VERDICT_IGNORED;
    v.mac = '0;
    v.idx = '0;
    if (w.operation == OP_LOAD) begin
      if (bound_count < TABLE_DEPTH) begin
        bound_ip[bound_count]  = w.sender_ip;
        bound_mac[bound_count] = w.sender_mac;
        bound_count++;
      end
    end else begin
      if (w.eth_type == ETH_TYPE_ARP && w.arp_opcode == OPCODE_REPLY) begin
        v.verdict = VERDICT_UNKNOWN;
        for (int i = 0; i < bound_count; i++) begin
          if (bound_ip[i] == w.sender_ip) begin
            v.mac = bound_mac[i];
            v.idx = 8'(i);
            v.verdict = (bound_mac[i] == w.sender_mac) ? VERDICT_CORRECT : VERDICT_POISON;
            break;
          end
        end
      end
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic flag_error(input string msg);
    if (mismatch_count < 10) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        judge_word(cur_word);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (frame_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          cur_word = frame_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.operation  <= cur_word.operation;
          in_ch.eth_type   <= cur_word.eth_type;
          in_ch.arp_opcode <= cur_word.arp_opcode;
          in_ch.sender_ip  <= cur_word.sender_ip;
          in_ch.sender_mac <= cur_word.sender_mac;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          flag_error($sformatf("unexpected word verdict=%0d mac=%h idx=%0d",
                               out_ch.verdict, out_ch.trusted_mac, out_ch.match_index));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.verdict !== want.verdict || out_ch.trusted_mac !== want.mac ||
              out_ch.match_index !== want.idx) begin
            flag_error($sformatf("expected verdict=%0d mac=%h idx=%0d, got %0d %h %0d",
                                 want.verdict, want.mac, want.idx, out_ch.verdict,
                                 out_ch.trusted_mac, out_ch.match_index));
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    int          roll;
    int          pick;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] et;
    logic [15:0] opc;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_LOAD;
    in_ch.eth_type   = '0;
    in_ch.arp_opcode = '0;
    in_ch.sender_ip  = '0;
    in_ch.sender_mac = '0;
    out_ch.ready     = 1'b0;

    // empty table and frames that are not arp replies
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'h0, 48'h0);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OP_CHECK, 16'h0800, OPCODE_REPLY, 32'h0, 48'h0);
    add_word(OP_CHECK, ETH_TYPE_ARP, 16'd1, 32'h0, 48'h0);
    add_word(OP_CHECK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OP_CHECK, 16'h0000, 16'h0000, 32'h0, 48'h0);
    // extremes and a duplicate ip
    add_word(OP_LOAD, 16'h0, 16'h0, 32'h0, 48'h0);
    add_word(OP_LOAD, 16'h0, 16'h0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OP_LOAD, 16'h0, 16'h0, 32'hC0A8_0001, 48'h0011_2233_4455);
    add_word(OP_LOAD, 16'h0, 16'h0, 32'hC0A8_0001, 48'h6677_8899_AABB);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'h0, 48'h0);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'h0, 48'hFFFF_FFFF_FFFF);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'hFFFF_FFFF, 48'h0);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'hC0A8_0001, 48'h6677_8899_AABB);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'hC0A8_0001, 48'h0011_2233_4455);
    add_word(OP_CHECK, ETH_TYPE_ARP, 16'd1, 32'hC0A8_0001, 48'h0011_2233_4455);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'h0A00_0001, 48'h0011_2233_4455);
    // load fields that only a check uses are don't care
    add_word(OP_LOAD, 16'hFFFF, 16'hFFFF, 32'h0A00_0001, 48'hA5A5_5A5A_A5A5);
    add_word(OP_CHECK, ETH_TYPE_ARP, OPCODE_REPLY, 32'h0A00_0001, 48'hA5A5_5A5A_A5A5);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ((stored_ips.size() < TABLE_DEPTH) ? 35 : 6)) begin
        ip = $urandom;
        if (stored_ips.size() != 0 && $urandom_range(0, 99) < 15)
          ip = stored_ips[$urandom_range(0, stored_ips.size() - 1)];
        add_word(OP_LOAD, 16'($urandom), 16'($urandom), ip, rand_mac());
      end else begin
        pick = $urandom_range(0, 99);
        et   = ETH_TYPE_ARP;
        opc  = OPCODE_REPLY;
        ip   = $urandom;
        mac  = rand_mac();
        if (stored_ips.size() != 0 && pick < 88) begin
          ip = stored_ips[$urandom_range(0, stored_ips.size() - 1)];
          if ($urandom_range(0, 1)) mac = first_mac_of[ip];
          else if ($urandom_range(0, 1)) mac = first_mac_of[ip] ^ (48'd1 << $urandom_range(0, 47));
        end
        if (pick >= 75 && pick < 88) begin
          // near miss on ethertype or opcode
          if ($urandom_range(0, 1)) begin
            opc = 16'($urandom_range(0, 65535));
            if (opc == OPCODE_REPLY) opc = 16'd1;
          end else begin
            et = 16'($urandom_range(0, 65535));
            if (et == ETH_TYPE_ARP) et = 16'h0800;
          end
        end else if (pick >= 88) begin
          et  = 16'($urandom_range(0, 65535));
          opc = 16'($urandom_range(0, 65535));
        end
        add_word(OP_CHECK, et, opc, ip, mac);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while ((words_sent < total_words || pending_verdicts.size() != 0) &&
           stall_cycles < STALL_LIMIT)
      @(posedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule
